// ----- design/srr_pkg.sv -----
// Shared types and constants of the selective repeat receiver
`default_nettype none
package srr_pkg;

  localparam int PayloadBytes = 20;
  localparam int PayloadBits  = 8 * PayloadBytes;
  localparam int SeqW         = 16;
  localparam int CheckW       = 18;
  localparam int CfgW         = 5;

  localparam logic [CfgW-1:0] WinReset = 5'd8;

  localparam logic KindDeliver = 1'b0;
  localparam logic KindAck     = 1'b1;

  typedef logic [PayloadBits-1:0] payload_t;

  typedef struct packed {
    logic [SeqW-1:0]   seq_num;
    logic [SeqW-1:0]   ack_num;
    logic [CheckW-1:0] check_value;
    logic [63:0]       payload_word0;
    logic [63:0]       payload_word1;
    logic [31:0]       payload_word2;
  } pkt_t;

  typedef struct packed {
    logic              result_kind;
    logic [SeqW-1:0]   out_seq;
    logic [SeqW-1:0]   out_ack;
    logic [CheckW-1:0] out_check;
    logic [63:0]       out_word0;
    logic [63:0]       out_word1;
    logic [31:0]       out_word2;
    logic              run_last;
  } res_t;

endpackage
`default_nettype wire

// ----- design/selective_repeat_receiver.sv -----
// Selective repeat receiver: window check, slot buffer and in-order delivery
//
// Requests arrive on pkt (pkt_valid / pkt_stall) and results leave on res
// (res_valid / res_stall); the receiving side of each channel drives stall.
// A request is taken only when the sequencer is idle; a waiting result in
// the output register does not hold off the next request.
// Per request, the sequencer steps through sum and decide; a packet that
// gives no result then returns to idle, one that is only acknowledged goes
// on to the ack state, and each delivery adds a slot memory read and an
// output register load ahead of the ack.
// res_valid rises when an ack or a delivery is loaded into the output
// register; a stalled result holds there and the sequencer waits on it
// before loading the next result.
// The user writes the window width through wr_en / wr_data only while the
// block is idle; the block itself does not enforce this.
// Reset sets the window width to 8, the window base to 0 and clears the slot
// filled bits; the payload memory needs no clearing pass.
`default_nettype none
module selective_repeat_receiver import srr_pkg::*; #(
  parameter int WINDOW_MAX = 16
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            pkt_valid,
  output logic                 pkt_stall,
  input  wire pkt_t            pkt,
  output logic                 res_valid,
  input  wire logic            res_stall,
  output res_t                 res,
  input  wire logic            wr_en,
  input  wire logic [CfgW-1:0] wr_data
);

  localparam int IdxW = $clog2(WINDOW_MAX);
  localparam int WinW = $clog2(WINDOW_MAX + 1);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SUM    = 6'b000010,
    S_DECIDE = 6'b000100,
    S_READ   = 6'b001000,
    S_EMIT   = 6'b010000,
    S_ACK    = 6'b100000
  } state_t;

  state_t            state;
  state_t            state_next;
  logic [CfgW-1:0]   win_cfg;
  logic [SeqW-1:0]   base;
  logic [IdxW-1:0]   ptr;
  logic [WINDOW_MAX-1:0] filled;
  pkt_t              pkt_r;
  logic [CheckW-1:0] sum_r;
  payload_t          copy_r;
  logic              in_win_r;
  logic              below_ok_r;
  logic              off_zero_r;
  logic [IdxW-1:0]   phys_r;

  logic [CheckW-1:0] sum_c;
  payload_t          copy_c;
  logic [WinW-1:0]   win;
  logic [SeqW-1:0]   off;
  logic [SeqW-1:0]   below;
  logic [IdxW-1:0]   phys;
  logic [IdxW-1:0]   ptr_inc;
  logic              good;
  logic              store;
  logic              out_free;
  logic              mem_re;
  payload_t          rdata;

  function automatic logic [IdxW-1:0] wrap_idx(input logic [IdxW:0] s);
    if (s >= (IdxW+1)'(WINDOW_MAX)) begin
      return IdxW'(s - (IdxW+1)'(WINDOW_MAX));
    end
    return IdxW'(s);
  endfunction

  srr_checksum u_checksum (
    .pkt  (pkt_r),
    .sum  (sum_c),
    .copy (copy_c)
  );

  srr_slot_mem #(
    .Depth (WINDOW_MAX),
    .IdxW  (IdxW)
  ) u_slot_mem (
    .clk   (clk),
    .we    (store),
    .waddr (phys_r),
    .wdata ({pkt_r.payload_word2, pkt_r.payload_word1, pkt_r.payload_word0}),
    .re    (mem_re),
    .raddr (ptr),
    .rdata (rdata)
  );

  always_comb begin
    if (win_cfg == '0) begin
      win = WinW'(1);
    end else if ({1'b0, win_cfg} > (CfgW+1)'(WINDOW_MAX)) begin
      win = WinW'(WINDOW_MAX);
    end else begin
      win = WinW'(win_cfg);
    end
  end

  assign off       = pkt_r.seq_num - base;
  assign below     = base - pkt_r.seq_num;
  assign phys      = wrap_idx({1'b0, ptr} + {1'b0, off[IdxW-1:0]});
  assign ptr_inc   = wrap_idx({1'b0, ptr} + (IdxW+1)'(1));
  assign good      = (sum_r == pkt_r.check_value);
  assign store     = (state == S_DECIDE) && good && in_win_r && !filled[phys_r];
  assign out_free  = !res_valid || !res_stall;
  assign mem_re    = (state == S_READ);
  assign pkt_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (pkt_valid) begin
          state_next = S_SUM;
        end
      end
      S_SUM: begin
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (store && off_zero_r) begin
          state_next = S_READ;
        end else if (good && (in_win_r || below_ok_r)) begin
          state_next = S_ACK;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_READ: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          state_next = filled[ptr_inc] ? S_READ : S_ACK;
        end
      end
      S_ACK: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      win_cfg     <= WinReset;
      base        <= '0;
      ptr         <= '0;
      filled      <= '0;
      res_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (wr_en) begin
        win_cfg <= wr_data;
      end
      if (store) begin
        filled[phys_r] <= 1'b1;
      end
      if (state == S_EMIT && out_free) begin
        filled[ptr] <= 1'b0;
        ptr         <= ptr_inc;
        base        <= base + SeqW'(1);
      end
      if ((state == S_EMIT || state == S_ACK) && out_free) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && pkt_valid) begin
      pkt_r <= pkt;
    end
    if (state == S_SUM) begin
      sum_r      <= sum_c;
      copy_r     <= copy_c;
      in_win_r   <= (off < SeqW'(win));
      below_ok_r <= (below != '0) && (below <= SeqW'(win));
      off_zero_r <= (off == '0);
      phys_r     <= phys;
    end
    if (state == S_EMIT && out_free) begin
      res.result_kind <= KindDeliver;
      res.out_seq     <= base;
      res.out_ack     <= '0;
      res.out_check   <= '0;
      res.out_word0   <= rdata[63:0];
      res.out_word1   <= rdata[127:64];
      res.out_word2   <= rdata[159:128];
      res.run_last    <= 1'b0;
    end else if (state == S_ACK && out_free) begin
      res.result_kind <= KindAck;
      res.out_seq     <= pkt_r.ack_num;
      res.out_ack     <= pkt_r.seq_num;
      res.out_check   <= sum_r;
      res.out_word0   <= copy_r[63:0];
      res.out_word1   <= copy_r[127:64];
      res.out_word2   <= copy_r[159:128];
      res.run_last    <= 1'b1;
    end
  end

  a_emit_filled: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> filled[ptr])
    else $error("delivery from an empty slot");

  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    ptr < IdxW'(WINDOW_MAX - 1) || ptr == IdxW'(WINDOW_MAX - 1))
    else $error("slot pointer out of range");

  a_ack_last: assert property (@(posedge clk) disable iff (rst)
    (state == S_ACK && out_free) |=> (res_valid && res.run_last))
    else $error("ack not marked as last result");

  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |=> (state == S_EMIT && pkt_stall))
    else $error("read not followed by delivery");

endmodule
`default_nettype wire

// ----- design/srr_checksum.sv -----
// Additive packet checksum and zero-terminated payload copy
`default_nettype none
module srr_checksum import srr_pkg::*; (
  input  wire pkt_t         pkt,
  output logic [CheckW-1:0] sum,
  output payload_t          copy
);

  localparam int GroupN = 4;
  localparam int GroupSize = PayloadBytes / GroupN;

  payload_t                 flat;
  logic [PayloadBytes-1:0]  nz;
  logic [PayloadBytes-1:0]  keep;
  logic [10:0]              group_sum [GroupN];
  logic [12:0]              byte_sum;

  assign flat = {pkt.payload_word2, pkt.payload_word1, pkt.payload_word0};

  always_comb begin
    for (int i = 0; i < PayloadBytes; i++) begin
      nz[i] = (flat[8*i +: 8] != 8'd0);
    end
    for (int i = 0; i < PayloadBytes; i++) begin
      keep[i] = &(nz | ~PayloadBytes'((64'd1 << (i + 1)) - 64'd1));
    end
    for (int i = 0; i < PayloadBytes; i++) begin
      copy[8*i +: 8] = keep[i] ? flat[8*i +: 8] : 8'd0;
    end
    for (int g = 0; g < GroupN; g++) begin
      group_sum[g] = 11'd0;
      for (int j = 0; j < GroupSize; j++) begin
        group_sum[g] = group_sum[g] + 11'(copy[8*(g*GroupSize+j) +: 8]);
      end
    end
    byte_sum = 13'(group_sum[0]) + 13'(group_sum[1]) + 13'(group_sum[2])
             + 13'(group_sum[3]);
    sum = CheckW'(byte_sum) + CheckW'(pkt.seq_num) + CheckW'(pkt.ack_num);
  end

endmodule
`default_nettype wire

// ----- design/srr_slot_mem.sv -----
// Slot payload memory, one write port and one registered read port
`default_nettype none
module srr_slot_mem import srr_pkg::*; #(
  parameter int Depth = 16,
  parameter int IdxW  = 4
) (
  input  wire logic            clk,
  input  wire logic            we,
  input  wire logic [IdxW-1:0] waddr,
  input  wire payload_t        wdata,
  input  wire logic            re,
  input  wire logic [IdxW-1:0] raddr,
  output payload_t             rdata
);

  payload_t mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire
